// File: rtl/core/salc_pkg.sv
package salc_pkg;

  // Geometry of the cache storage.
  localparam int MAX_SET_BITS = 6;
  localparam int MAX_WAYS     = 8;
  localparam int ADDRESS_BITS = 64;

  localparam int SETS         = 1 << MAX_SET_BITS;
  localparam int WAY_IDX_BITS = (MAX_WAYS > 1) ? $clog2(MAX_WAYS) : 1;
  localparam int WAY_CNT_BITS = $clog2(MAX_WAYS + 1);
  localparam int SHIFT_BITS   = 7;

  localparam logic [31:0] COUNT_MAX = 32'hFFFF_FFFF;

  // Access kinds carried on the action field.
  localparam logic [1:0] ACT_LOAD   = 2'd0;
  localparam logic [1:0] ACT_STORE  = 2'd1;
  localparam logic [1:0] ACT_MODIFY = 2'd2;
  localparam logic [1:0] ACT_IFETCH = 2'd3;

  // Register indexes on the configuration port (word address).
  localparam logic [1:0] REG_SET_BITS    = 2'd0;
  localparam logic [1:0] REG_WAYS        = 2'd1;
  localparam logic [1:0] REG_OFFSET_BITS = 2'd2;

  // One set row: a valid bit and a tag per way, way 0 the oldest.
  typedef struct packed {
    logic [MAX_WAYS-1:0]                   valid;
    logic [MAX_WAYS-1:0][ADDRESS_BITS-1:0] tag;
  } row_t;

  // Outcome of one lookup.
  typedef struct packed {
    logic hit;
    logic miss;
    logic evict;
  } lookup_t;

endpackage

// File: rtl/core/salc_row_update.sv
module salc_row_update (
  input  salc_pkg::row_t                          row_in,
  input  logic [salc_pkg::ADDRESS_BITS-1:0]       tag,
  input  logic [salc_pkg::WAY_CNT_BITS-1:0]       ways,
  output salc_pkg::row_t                          row_out,
  output salc_pkg::lookup_t                       flags
);

  logic [salc_pkg::MAX_WAYS-1:0]                             match;
  logic [salc_pkg::MAX_WAYS-1:0]                             stop;
  logic [salc_pkg::MAX_WAYS-1:0]                             valid_up;
  logic [salc_pkg::MAX_WAYS-1:0][salc_pkg::ADDRESS_BITS-1:0] tag_up;
  logic [salc_pkg::WAY_IDX_BITS-1:0]                         pos;
  logic [salc_pkg::WAY_IDX_BITS-1:0]                         last;
  logic                                                      found;

  // Neighbor one way younger, used when the gap is closed.
  assign valid_up = row_in.valid >> 1;
  assign tag_up   = row_in.tag >> salc_pkg::ADDRESS_BITS;

  always_comb begin
    // Each way in use matches on an empty line or an equal tag.
    for (int w = 0; w < salc_pkg::MAX_WAYS; w++) begin
      match[w] = (w < int'(ways)) && (!row_in.valid[w] || (row_in.tag[w] == tag));
    end
    found = |match;

    // The first matching way is where the access lands; a full miss evicts way 0.
    pos = '0;
    for (int w = salc_pkg::MAX_WAYS - 1; w >= 0; w--) begin
      if (match[w]) begin
        pos = salc_pkg::WAY_IDX_BITS'(w);
      end
    end
    if (!found) begin
      pos = '0;
    end

    // The shift stops at the last way in use or before an empty line.
    for (int k = 0; k < salc_pkg::MAX_WAYS; k++) begin
      stop[k] = ((k + 1) >= int'(ways)) || !valid_up[k];
    end
    last = pos;
    for (int k = salc_pkg::MAX_WAYS - 1; k >= 0; k--) begin
      if (stop[k] && (k >= int'(pos))) begin
        last = salc_pkg::WAY_IDX_BITS'(k);
      end
    end

    // Ways between the landing spot and the stop move one step older,
    // and the accessed tag becomes the most recent line.
    row_out = row_in;
    for (int w = 0; w < salc_pkg::MAX_WAYS; w++) begin
      if ((w >= int'(pos)) && (w < int'(last))) begin
        row_out.tag[w]   = tag_up[w];
        row_out.valid[w] = valid_up[w];
      end else if (w == int'(last)) begin
        row_out.tag[w]   = tag;
        row_out.valid[w] = 1'b1;
      end
    end

    flags.hit   = found && row_in.valid[pos];
    flags.miss  = !flags.hit;
    flags.evict = !found;
  end

endmodule

// File: rtl/core/set_assoc_lru_cache_sim.sv
// Set-associative LRU cache model. Each access transfer on the input side
// (load, store, modify or instruction fetch with a 64-bit byte address)
// yields exactly one result transfer with hit, miss, eviction and
// second-hit flags plus saturating running totals. The accept cycle reads
// the whole set row (all ways' tags and valid bits) from a synchronous row
// memory into a register; in the update state, once the result side can
// take a result, all ways are compared in parallel, the reordered row is
// written back (not for an instruction fetch) and the result register is
// loaded; only then does the block take the next access. A per-row
// initialized flag, cleared by reset, makes an untouched set read as
// empty, so no clearing pass follows reset.
// Registers on the APB port: 0x0 set index bits, 0x4 ways in use,
// 0x8 offset bits; write them only while no access is in flight.
module set_assoc_lru_cache_sim (
  input  logic        clk,
  input  logic        rst,
  // Access channel.
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  action,
  input  logic [63:0] address,
  // Result channel.
  output logic        out_valid,
  input  logic        out_stall,
  output logic        was_hit,
  output logic        was_miss,
  output logic        was_eviction,
  output logic        second_hit,
  output logic [31:0] hit_total,
  output logic [31:0] miss_total,
  output logic [31:0] eviction_total,
  // Configuration port.
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  typedef enum logic [1:0] {
    ST_IDLE   = 2'b01,
    ST_UPDATE = 2'b10
  } state_t;

  state_t state;

  logic [2:0] set_index_bits;
  logic [3:0] ways_in_use;
  logic [5:0] offset_bits;

  logic [salc_pkg::ADDRESS_BITS-1:0] addr;
  logic [2:0]                        sb_eff;
  logic [salc_pkg::WAY_CNT_BITS-1:0] ways_eff;
  logic [salc_pkg::SHIFT_BITS-1:0]   tag_shift;
  logic [salc_pkg::ADDRESS_BITS-1:0] in_tag;
  logic [salc_pkg::ADDRESS_BITS-1:0] addr_down;
  logic [salc_pkg::MAX_SET_BITS-1:0] set_mask;
  logic [salc_pkg::MAX_SET_BITS-1:0] in_set;

  logic [salc_pkg::ADDRESS_BITS-1:0] tag_q;
  logic [salc_pkg::MAX_SET_BITS-1:0] set_q;
  logic [1:0]                        action_q;

  salc_pkg::row_t    row_mem [salc_pkg::SETS];
  logic [salc_pkg::SETS-1:0] row_init;
  salc_pkg::row_t    rd_row;
  logic              rd_init;
  salc_pkg::row_t    lookup_row;
  salc_pkg::row_t    new_row;
  salc_pkg::lookup_t flags;

  logic        accept;
  logic        finish;
  logic        active;
  logic        wr_en;
  logic        is_modify;
  logic [31:0] hit_cnt;
  logic [31:0] miss_cnt;
  logic [31:0] evict_cnt;
  logic [31:0] hit_once;
  logic [31:0] hit_cnt_next;
  logic [31:0] miss_cnt_next;
  logic [31:0] evict_cnt_next;

  // Configuration registers; writes complete in the access phase.
  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      set_index_bits <= 3'd4;
      ways_in_use    <= 4'd1;
      offset_bits    <= 6'd4;
    end else if (psel && penable && pwrite) begin
      case (paddr[3:2])
        salc_pkg::REG_SET_BITS:    set_index_bits <= pwdata[2:0];
        salc_pkg::REG_WAYS:        ways_in_use    <= pwdata[3:0];
        salc_pkg::REG_OFFSET_BITS: offset_bits    <= pwdata[5:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[3:2])
      salc_pkg::REG_SET_BITS:    prdata = 32'(set_index_bits);
      salc_pkg::REG_WAYS:        prdata = 32'(ways_in_use);
      salc_pkg::REG_OFFSET_BITS: prdata = 32'(offset_bits);
      default:                   prdata = '0;
    endcase
  end

  // Clamp the configured geometry to what the storage holds.
  always_comb begin
    if (32'(set_index_bits) > salc_pkg::MAX_SET_BITS) begin
      sb_eff = 3'(salc_pkg::MAX_SET_BITS);
    end else begin
      sb_eff = set_index_bits;
    end
    if (ways_in_use == 4'd0) begin
      ways_eff = salc_pkg::WAY_CNT_BITS'(1);
    end else if (32'(ways_in_use) > salc_pkg::MAX_WAYS) begin
      ways_eff = salc_pkg::WAY_CNT_BITS'(salc_pkg::MAX_WAYS);
    end else begin
      ways_eff = salc_pkg::WAY_CNT_BITS'(ways_in_use);
    end
  end

  // Address split into tag and set index; shifts past the word give zero.
  assign addr      = address[salc_pkg::ADDRESS_BITS-1:0];
  assign tag_shift = salc_pkg::SHIFT_BITS'(sb_eff) + salc_pkg::SHIFT_BITS'(offset_bits);
  assign in_tag    = (32'(tag_shift) >= salc_pkg::ADDRESS_BITS) ? '0 : (addr >> tag_shift);
  assign addr_down = (32'(offset_bits) >= salc_pkg::ADDRESS_BITS) ? '0 : (addr >> offset_bits);
  assign set_mask  = ~({salc_pkg::MAX_SET_BITS{1'b1}} << sb_eff);
  assign in_set    = addr_down[salc_pkg::MAX_SET_BITS-1:0] & set_mask;

  // Handshake control.
  assign in_stall = (state != ST_IDLE);
  assign accept   = in_valid && (state == ST_IDLE);
  assign finish   = (state == ST_UPDATE) && (!out_valid || !out_stall);

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      out_valid <= 1'b0;
    end else begin
      case (state)
        ST_IDLE: begin
          if (accept) begin
            state <= ST_UPDATE;
          end
        end
        ST_UPDATE: begin
          if (finish) begin
            state <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
      if (finish) begin
        out_valid <= 1'b1;
      end else if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Capture the split access on acceptance.
  always_ff @(posedge clk) begin
    if (accept) begin
      tag_q    <= in_tag;
      set_q    <= in_set;
      action_q <= action;
    end
  end

  // Row memory: read on acceptance, written back when an access other than an instruction fetch finishes.
  // Only one access is in flight, so a read never overlaps a pending write.
  always_ff @(posedge clk) begin
    if (accept) begin
      rd_row <= row_mem[in_set];
    end
    if (wr_en) begin
      row_mem[set_q] <= new_row;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      row_init <= '0;
      rd_init  <= 1'b0;
    end else begin
      if (accept) begin
        rd_init <= row_init[in_set];
      end
      if (wr_en) begin
        row_init[set_q] <= 1'b1;
      end
    end
  end

  // A row never written reads as all ways empty.
  always_comb begin
    lookup_row = rd_row;
    if (!rd_init) begin
      lookup_row.valid = '0;
    end
  end

  salc_row_update u_row_update (
    .row_in  (lookup_row),
    .tag     (tag_q),
    .ways    (ways_eff),
    .row_out (new_row),
    .flags   (flags)
  );

  assign active    = (action_q != salc_pkg::ACT_IFETCH);
  assign is_modify = (action_q == salc_pkg::ACT_MODIFY);
  assign wr_en     = finish && active;

  // Saturating totals; a modify may add two hits.
  always_comb begin
    hit_once       = (flags.hit && hit_cnt != salc_pkg::COUNT_MAX) ? hit_cnt + 32'd1 : hit_cnt;
    hit_cnt_next   = (is_modify && hit_once != salc_pkg::COUNT_MAX) ? hit_once + 32'd1
                                                                    : hit_once;
    miss_cnt_next  = (flags.miss && miss_cnt != salc_pkg::COUNT_MAX) ? miss_cnt + 32'd1
                                                                     : miss_cnt;
    evict_cnt_next = (flags.evict && evict_cnt != salc_pkg::COUNT_MAX) ? evict_cnt + 32'd1
                                                                       : evict_cnt;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      hit_cnt   <= '0;
      miss_cnt  <= '0;
      evict_cnt <= '0;
    end else if (wr_en) begin
      hit_cnt   <= hit_cnt_next;
      miss_cnt  <= miss_cnt_next;
      evict_cnt <= evict_cnt_next;
    end
  end

  // Result flags; the totals are the counters, which hold while a result waits.
  always_ff @(posedge clk) begin
    if (finish) begin
      was_hit      <= active && flags.hit;
      was_miss     <= active && flags.miss;
      was_eviction <= active && flags.evict;
      second_hit   <= active && is_modify;
    end
  end

  assign hit_total      = hit_cnt;
  assign miss_total     = miss_cnt;
  assign eviction_total = evict_cnt;

endmodule

// File: rtl/core/salc_checker.sv
module salc_checker (
  input logic        clk,
  input logic        rst,
  input logic        in_valid,
  input logic        in_stall,
  input logic        out_valid,
  input logic        out_stall,
  input logic        was_hit,
  input logic        was_eviction,
  input logic [31:0] hit_total,
  input logic [31:0] eviction_total
);

  // Reset leaves no result pending.
  a_reset_empty: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("result pending after reset");

  // An accepted access holds off the next one: the stall is up in the cycle after acceptance.
  a_one_in_flight: assert property (@(posedge clk) disable iff (rst)
    (in_valid && !in_stall) |=> in_stall)
    else $error("second access accepted while one is in flight");

  // A new result only follows a cycle in which an access was being worked on.
  a_result_source: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(in_stall))
    else $error("result appeared without an access in flight");

  // A waiting result keeps its flags and totals.
  a_result_holds: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_stall) |=> out_valid && $stable(was_hit) && $stable(was_eviction)
      && $stable(hit_total) && $stable(eviction_total))
    else $error("stalled result changed");

endmodule

bind set_assoc_lru_cache_sim salc_checker u_salc_checker (.*);
